FILE: src/modbus_slave_coil_register_map_macros.svh
// assertion helpers used by the rtl file mscrm_ctrl.sv
`ifndef MODBUS_SLAVE_COIL_REGISTER_MAP_MACROS_SVH
`define MODBUS_SLAVE_COIL_REGISTER_MAP_MACROS_SVH

// property checked on every clock edge outside reset
`define MSCRM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define MSCRM_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

FILE: src/mscrm_pkg.sv
package mscrm_pkg;

	localparam logic [2:0] ACT_RD_COILS  = 3'd0;
	localparam logic [2:0] ACT_WR_COIL   = 3'd1;
	localparam logic [2:0] ACT_WR_COILS  = 3'd2;
	localparam logic [2:0] ACT_RD_INPUTS = 3'd3;
	localparam logic [2:0] ACT_RD_IREGS  = 3'd4;
	localparam logic [2:0] ACT_RD_REGS   = 3'd5;
	localparam logic [2:0] ACT_WR_REG    = 3'd6;
	localparam logic [2:0] ACT_WR_REGS   = 3'd7;

	localparam logic [15:0] COIL_ON = 16'hff00;
	localparam int DATA_BITS = 64;
	localparam int DATA_WORDS = 4;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  request_addr;
		logic [15:0] start_index;
		logic [15:0] count_or_value;
		logic [63:0] write_payload;
	} req_t;

	typedef struct packed {
		logic [7:0]  reply_addr;
		logic [2:0]  reply_action;
		logic [15:0] echo_start;
		logic [15:0] echo_count;
		logic [7:0]  byte_count;
		logic [63:0] reply_data;
		logic [31:0] coil_outputs;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic addr_hit;
	} stat_t;

endpackage

FILE: src/mscrm_datapath.sv
module mscrm_datapath #(
	parameter int COIL_COUNT = 32,
	parameter int HOLD_COUNT = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mscrm_pkg::cmd_t cmd,
	input  mscrm_pkg::req_t req,
	output mscrm_pkg::stat_t stat,
	output mscrm_pkg::rsp_t rsp
);
	import mscrm_pkg::*;

	req_t             req_q;
	logic [COIL_COUNT-1:0] coil_q;
	logic [15:0]      hold_q [HOLD_COUNT];
	rsp_t             rsp_q;

	logic [COIL_COUNT-1:0] coil_next;
	logic [15:0]      hold_next [HOLD_COUNT];
	rsp_t             rsp_next;
	logic             hit;

	assign hit = (req_q.request_addr == 8'd0) || ({8'd0, req_q.request_addr} == hold_q[0]);
	assign stat.addr_hit = hit;
	assign rsp = rsp_q;

	always_comb begin
		logic [16:0] cnt_p7;
		logic [13:0] bit_bytes;
		logic [16:0] word_bytes;
		logic [7:0]  bit_bytes_sat;
		logic [7:0]  word_bytes_sat;
		logic [6:0]  n_coil;
		logic [2:0]  n_reg;
		logic [63:0] coil_rd;
		logic [63:0] reg_rd;
		logic [15:0] off;
		cnt_p7 = {1'b0, req_q.count_or_value} + 17'd7;
		bit_bytes = cnt_p7[16:3];
		bit_bytes_sat = (|bit_bytes[13:8]) ? 8'hff : bit_bytes[7:0];
		word_bytes = {req_q.count_or_value, 1'b0};
		word_bytes_sat = (|word_bytes[16:8]) ? 8'hff : word_bytes[7:0];
		n_coil = (req_q.count_or_value > 16'(DATA_BITS)) ? 7'(DATA_BITS)
			: req_q.count_or_value[6:0];
		n_reg = (req_q.count_or_value > 16'(DATA_WORDS)) ? 3'(DATA_WORDS)
			: req_q.count_or_value[2:0];

		// each stored item lands at its offset from the start index
		coil_rd = '0;
		for (int j = 0; j < COIL_COUNT; j++) begin
			off = 16'(j) - req_q.start_index;
			if (off < {9'd0, n_coil})
				coil_rd = coil_rd | (64'(coil_q[j]) << off[5:0]);
		end
		reg_rd = '0;
		for (int j = 0; j < HOLD_COUNT; j++) begin
			off = 16'(j) - req_q.start_index;
			if (off < {13'd0, n_reg})
				reg_rd = reg_rd | (64'(hold_q[j]) << {off[1:0], 4'd0});
		end

		coil_next = coil_q;
		for (int j = 0; j < HOLD_COUNT; j++)
			hold_next[j] = hold_q[j];

		rsp_next.reply_addr = hold_q[0][7:0];
		rsp_next.reply_action = req_q.action;
		rsp_next.echo_start = req_q.start_index;
		rsp_next.echo_count = req_q.count_or_value;
		rsp_next.byte_count = 8'd0;
		rsp_next.reply_data = '0;

		unique case (req_q.action) inside
			ACT_RD_COILS: begin
				rsp_next.byte_count = bit_bytes_sat;
				rsp_next.reply_data = coil_rd;
			end
			ACT_RD_INPUTS: begin
				rsp_next.byte_count = bit_bytes_sat;
			end
			ACT_RD_IREGS: begin
				rsp_next.byte_count = word_bytes_sat;
			end
			ACT_RD_REGS: begin
				rsp_next.byte_count = word_bytes_sat;
				rsp_next.reply_data = reg_rd;
			end
			ACT_WR_COIL: begin
				for (int j = 0; j < COIL_COUNT; j++) begin
					if (req_q.start_index == 16'(j)) begin
						if (req_q.count_or_value == 16'd0)
							coil_next[j] = 1'b0;
						else if (req_q.count_or_value == COIL_ON)
							coil_next[j] = 1'b1;
					end
				end
			end
			ACT_WR_COILS: begin
				for (int j = 0; j < COIL_COUNT; j++) begin
					off = 16'(j) - req_q.start_index;
					if (off < {9'd0, n_coil})
						coil_next[j] = req_q.write_payload[off[5:0]];
				end
			end
			ACT_WR_REG: begin
				for (int j = 0; j < HOLD_COUNT; j++)
					if (req_q.start_index == 16'(j))
						hold_next[j] = req_q.count_or_value;
			end
			ACT_WR_REGS: begin
				for (int j = 0; j < HOLD_COUNT; j++) begin
					off = 16'(j) - req_q.start_index;
					if (off < {13'd0, n_reg})
						hold_next[j] = req_q.write_payload[{off[1:0], 4'd0} +: 16];
				end
			end
			default: begin
			end
		endcase

		if (req_q.action inside {ACT_RD_COILS, ACT_RD_INPUTS, ACT_RD_IREGS, ACT_RD_REGS}) begin
			rsp_next.echo_start = 16'd0;
			rsp_next.echo_count = 16'd0;
		end
		rsp_next.coil_outputs = 32'(coil_next);
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
		if (cmd.exec && hit)
			rsp_q <= rsp_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coil_q <= '0;
			for (int j = 0; j < HOLD_COUNT; j++)
				hold_q[j] <= (j == 0) ? 16'd1 : 16'd0;
		end else if (cmd.exec && hit) begin
			coil_q <= coil_next;
			for (int j = 0; j < HOLD_COUNT; j++)
				hold_q[j] <= hold_next[j];
		end
	end

endmodule

FILE: src/mscrm_ctrl.sv
`include "modbus_slave_coil_register_map_macros.svh"

module mscrm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mscrm_pkg::stat_t stat,
	output mscrm_pkg::cmd_t  cmd,
	output logic             busy,
	output logic             done
);
	import mscrm_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	assign busy = (state_q == ST_EXEC);
	assign cmd.load = start && !busy;
	assign cmd.exec = (state_q == ST_EXEC);
	assign done = done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// dropped requests give no strobe
			done_q <= cmd.exec && stat.addr_hit;
		end
	end

	`MSCRM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not execute")
	`MSCRM_ASSERT_NEXT(a_exec_one_cycle, busy, !busy, "execute state held too long")
	`MSCRM_ASSERT(a_done_after_exec, !done || $past(state_q == ST_EXEC), "reply without execute")
	`MSCRM_ASSERT(a_done_idle, !(done && busy), "reply strobe while busy")

endmodule

FILE: src/modbus_slave_coil_register_map.sv
// one request accepted when start is high and busy is low; busy then stays high one cycle
// the reply strobe done rises at the edge after the accepting edge, and the reply is registered
// at that same edge and held until the next answered request; no request is accepted while
// the execute state reads and updates the coil and holding registers; addressed-away requests
// give no strobe
// asynchronous reset clears the coils, loads holding register 0 with 1 and the rest with 0
module modbus_slave_coil_register_map #(
	parameter int COIL_COUNT = 32,
	parameter int HOLD_COUNT = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mscrm_pkg::req_t req,
	output logic            busy,
	output logic            done,
	output mscrm_pkg::rsp_t rsp
);
	import mscrm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mscrm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mscrm_datapath #(
		.COIL_COUNT (COIL_COUNT),
		.HOLD_COUNT (HOLD_COUNT)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

FILE: test/tb_top.sv
module tb_top;
	import mscrm_pkg::*;

	localparam int COIL_N = 32;
	localparam int HOLD_N = 3;
	localparam int TOTAL_REQUESTS = 1250;

	typedef enum {ROW_PREDICT, ROW_TYPED, ROW_DROPPED} row_kind_t;

	typedef struct {
		req_t      r;
		row_kind_t kind;
		rsp_t      want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	// shadow of the coil bits and holding words
	logic [31:0] coil_img;
	logic [15:0] hold_img [HOLD_N];

	rsp_t      expected_replies[$];
	plan_row_t plan[$];

	int mismatches = 0;
	int sent_requests = 0;
	int dropped_requests = 0;
	int answered_requests = 0;
	int checked_replies = 0;
	int action_count [8];

	modbus_slave_coil_register_map DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [7:0] byte_len(input int unsigned n);
		return (n > 255) ? 8'd255 : n[7:0];
	endfunction

	// applies one request to the shadow state; returns 0 when the address filter drops it
	function automatic bit predict_reply(input req_t r, output rsp_t e);
		int unsigned cnt;
		int unsigned n;
		logic [15:0] idx;
		e = '0;
		cnt = 32'(r.count_or_value);
		if (r.request_addr != 8'd0 && {8'd0, r.request_addr} != hold_img[0])
			return 1'b0;
		e.reply_addr = hold_img[0][7:0];
		e.reply_action = r.action;
		case (r.action)
			ACT_RD_COILS: begin
				e.byte_count = byte_len((cnt + 7) / 8);
				n = (cnt < 64) ? cnt : 64;
				for (int i = 0; i < n; i++) begin
					idx = 16'(r.start_index + i);
					if (idx < COIL_N && coil_img[idx[4:0]])
						e.reply_data[i] = 1'b1;
				end
			end
			ACT_WR_COIL: begin
				e.echo_start = r.start_index;
				e.echo_count = r.count_or_value;
				if (r.start_index < COIL_N) begin
					if (r.count_or_value == 16'd0)
						coil_img[r.start_index[4:0]] = 1'b0;
					else if (r.count_or_value == COIL_ON)
						coil_img[r.start_index[4:0]] = 1'b1;
				end
			end
			ACT_WR_COILS: begin
				e.echo_start = r.start_index;
				e.echo_count = r.count_or_value;
				n = (cnt < 64) ? cnt : 64;
				for (int i = 0; i < n; i++) begin
					idx = 16'(r.start_index + i);
					if (idx < COIL_N)
						coil_img[idx[4:0]] = r.write_payload[i];
				end
			end
			ACT_RD_INPUTS: e.byte_count = byte_len((cnt + 7) / 8);
			ACT_RD_IREGS: e.byte_count = byte_len(cnt * 2);
			ACT_RD_REGS: begin
				e.byte_count = byte_len(cnt * 2);
				n = (cnt < 4) ? cnt : 4;
				for (int i = 0; i < n; i++) begin
					idx = 16'(r.start_index + i);
					if (idx < HOLD_N)
						e.reply_data[16*i +: 16] = hold_img[idx];
				end
			end
			ACT_WR_REG: begin
				e.echo_start = r.start_index;
				e.echo_count = r.count_or_value;
				if (r.start_index < HOLD_N)
					hold_img[r.start_index] = r.count_or_value;
			end
			default: begin
				e.echo_start = r.start_index;
				e.echo_count = r.count_or_value;
				n = (cnt < 4) ? cnt : 4;
				for (int i = 0; i < n; i++) begin
					idx = 16'(r.start_index + i);
					if (idx < HOLD_N)
						hold_img[idx] = r.write_payload[16*i +: 16];
				end
			end
		endcase
		e.coil_outputs = coil_img;
		return 1'b1;
	endfunction

	// mostly addressed to this device or broadcast, so the state keeps moving
	function automatic req_t random_request();
		req_t r;
		int unsigned sel;
		int unsigned n;
		int unsigned first_hit;
		r.action = 3'($urandom_range(0, 7));
		sel = $urandom_range(0, 99);
		if (sel < 40)
			r.request_addr = 8'd0;
		else if (sel < 85)
			r.request_addr = hold_img[0][7:0];
		else
			r.request_addr = 8'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 70)
			r.start_index = 16'($urandom_range(0, 40));
		else if (sel < 85)
			r.start_index = 16'($urandom_range(65500, 65535));
		else
			r.start_index = 16'($urandom);
		sel = $urandom_range(0, 99);
		case (r.action)
			ACT_WR_COIL: begin
				if (sel < 40)
					r.count_or_value = 16'd0;
				else if (sel < 80)
					r.count_or_value = COIL_ON;
				else
					r.count_or_value = 16'($urandom);
			end
			ACT_WR_REG: begin
				r.count_or_value = 16'($urandom);
				if (r.start_index == 16'd0 && sel < 85)
					r.count_or_value = 16'($urandom_range(1, 255));
			end
			default: begin
				if (sel < 50)
					r.count_or_value = 16'($urandom_range(0, 70));
				else if (sel < 75)
					r.count_or_value = 16'($urandom_range(0, 8));
				else
					r.count_or_value = 16'($urandom);
			end
		endcase
		r.write_payload = {$urandom, $urandom};
		// keep the device address reachable when a block write lands on register 0
		if (r.action == ACT_WR_REGS) begin
			n = (r.count_or_value < 4) ? 32'(r.count_or_value) : 4;
			first_hit = (65536 - 32'(r.start_index)) & 32'hffff;
			if (first_hit < n && $urandom_range(0, 99) < 85)
				r.write_payload[16*first_hit +: 16] = 16'($urandom_range(1, 255));
		end
		return r;
	endfunction

	task automatic add_row(input req_t r, input row_kind_t kind, input rsp_t want);
		plan_row_t row;
		row.r = r;
		row.kind = kind;
		row.want = want;
		plan.push_back(row);
	endtask

	task automatic send_request(input req_t r, input row_kind_t kind, input rsp_t want);
		rsp_t e;
		bit replied;
		start = 1'b1;
		req = r;
		forever begin
			@(posedge clk);
			if (busy === 1'b0)
				break;
		end
		replied = predict_reply(r, e);
		if (kind == ROW_TYPED) begin
			expected_replies.push_back(want);
			answered_requests++;
			action_count[r.action]++;
		end else if (kind == ROW_PREDICT && replied) begin
			expected_replies.push_back(e);
			answered_requests++;
			action_count[r.action]++;
		end else begin
			dropped_requests++;
		end
		sent_requests++;
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin : reply_check
		rsp_t exp_r;
		if (arst_n && done === 1'b1) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("reply with no request waiting", 64'd0, 64'd0);
			end else begin
				exp_r = expected_replies.pop_front();
				check_field("reply_addr", 64'(rsp.reply_addr), 64'(exp_r.reply_addr));
				check_field("reply_action", 64'(rsp.reply_action),
					64'(exp_r.reply_action));
				check_field("echo_start", 64'(rsp.echo_start), 64'(exp_r.echo_start));
				check_field("echo_count", 64'(rsp.echo_count), 64'(exp_r.echo_count));
				check_field("byte_count", 64'(rsp.byte_count), 64'(exp_r.byte_count));
				check_field("reply_data", rsp.reply_data, exp_r.reply_data);
				check_field("coil_outputs", 64'(rsp.coil_outputs),
					64'(exp_r.coil_outputs));
				checked_replies++;
			end
		end
	end

	initial begin
		int k;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		coil_img = '0;
		hold_img[0] = 16'd1;
		for (int i = 1; i < HOLD_N; i++)
			hold_img[i] = 16'd0;
		for (int i = 0; i < 8; i++)
			action_count[i] = 0;

		// request fields: action, addr, start, count or value, payload
		// reply fields: addr, action, echo start, echo count, bytes, data, coils
		add_row({ACT_RD_REGS, 8'd1, 16'd0, 16'd3, 64'd0}, ROW_TYPED,
			{8'd1, ACT_RD_REGS, 16'd0, 16'd0, 8'd6, 64'd1, 32'd0});
		add_row({ACT_RD_COILS, 8'd2, 16'd0, 16'd8, 64'd0}, ROW_DROPPED, '0);
		add_row({ACT_WR_COIL, 8'd0, 16'd0, COIL_ON, 64'd0}, ROW_TYPED,
			{8'd1, ACT_WR_COIL, 16'd0, COIL_ON, 8'd0, 64'd0, 32'h0000_0001});
		add_row({ACT_WR_COIL, 8'd1, 16'd31, COIL_ON, 64'd0}, ROW_TYPED,
			{8'd1, ACT_WR_COIL, 16'd31, COIL_ON, 8'd0, 64'd0, 32'h8000_0001});
		// coil value neither off nor on is echoed but ignored
		add_row({ACT_WR_COIL, 8'd1, 16'd5, 16'h1234, 64'd0}, ROW_TYPED,
			{8'd1, ACT_WR_COIL, 16'd5, 16'h1234, 8'd0, 64'd0, 32'h8000_0001});
		add_row({ACT_WR_COIL, 8'd0, 16'd32, COIL_ON, 64'd0}, ROW_TYPED,
			{8'd1, ACT_WR_COIL, 16'd32, COIL_ON, 8'd0, 64'd0, 32'h8000_0001});
		add_row({ACT_WR_COIL, 8'd1, 16'd0, 16'd0, 64'd0}, ROW_TYPED,
			{8'd1, ACT_WR_COIL, 16'd0, 16'd0, 8'd0, 64'd0, 32'h8000_0000});
		add_row({ACT_WR_COILS, 8'd1, 16'd0, 16'd32, {64{1'b1}}}, ROW_TYPED,
			{8'd1, ACT_WR_COILS, 16'd0, 16'd32, 8'd0, 64'd0, 32'hffff_ffff});
		add_row({ACT_RD_COILS, 8'd1, 16'd0, 16'd0, 64'd0}, ROW_TYPED,
			{8'd1, ACT_RD_COILS, 16'd0, 16'd0, 8'd0, 64'd0, 32'hffff_ffff});
		add_row({ACT_RD_COILS, 8'd1, 16'd16, 16'hffff, 64'd0}, ROW_TYPED,
			{8'd1, ACT_RD_COILS, 16'd0, 16'd0, 8'd255, 64'hffff, 32'hffff_ffff});
		add_row({ACT_RD_INPUTS, 8'd1, 16'd7, 16'hffff, 64'd0}, ROW_TYPED,
			{8'd1, ACT_RD_INPUTS, 16'd0, 16'd0, 8'd255, 64'd0, 32'hffff_ffff});
		add_row({ACT_RD_INPUTS, 8'd0, 16'd0, 16'd9, 64'd0}, ROW_TYPED,
			{8'd1, ACT_RD_INPUTS, 16'd0, 16'd0, 8'd2, 64'd0, 32'hffff_ffff});
		add_row({ACT_RD_IREGS, 8'd1, 16'd0, 16'd127, 64'd0}, ROW_TYPED,
			{8'd1, ACT_RD_IREGS, 16'd0, 16'd0, 8'd254, 64'd0, 32'hffff_ffff});
		add_row({ACT_RD_IREGS, 8'd1, 16'd0, 16'd128, 64'd0}, ROW_TYPED,
			{8'd1, ACT_RD_IREGS, 16'd0, 16'd0, 8'd255, 64'd0, 32'hffff_ffff});
		add_row({ACT_WR_REG, 8'd1, 16'd1, 16'hffff, 64'd0}, ROW_TYPED,
			{8'd1, ACT_WR_REG, 16'd1, 16'hffff, 8'd0, 64'd0, 32'hffff_ffff});
		add_row({ACT_WR_REG, 8'd1, 16'd3, 16'd5, 64'd0}, ROW_TYPED,
			{8'd1, ACT_WR_REG, 16'd3, 16'd5, 8'd0, 64'd0, 32'hffff_ffff});
		add_row({ACT_WR_COILS, 8'd0, 16'd30, 16'd64, {$urandom, $urandom}}, ROW_PREDICT, '0);
		add_row({ACT_WR_COILS, 8'd1, 16'hfff0, 16'd64, {$urandom, $urandom}},
			ROW_PREDICT, '0);
		add_row({ACT_RD_COILS, 8'd1, 16'hffe0, 16'd64, 64'd0}, ROW_PREDICT, '0);
		// index wraps from 0xffff to 0 and moves the device address to 7
		add_row({ACT_WR_REGS, 8'd1, 16'hffff, 16'd4, 64'h00aa_5555_0007_dead},
			ROW_PREDICT, '0);
		add_row({ACT_RD_REGS, 8'd7, 16'hffff, 16'd4, 64'd0}, ROW_PREDICT, '0);
		add_row({ACT_RD_REGS, 8'd1, 16'd0, 16'd1, 64'd0}, ROW_DROPPED, '0);
		// device address above 255 answers only broadcasts
		add_row({ACT_WR_REG, 8'd7, 16'd0, 16'h01ff, 64'd0}, ROW_PREDICT, '0);
		add_row({ACT_RD_COILS, 8'hff, 16'd0, 16'd8, 64'd0}, ROW_DROPPED, '0);
		add_row({ACT_RD_REGS, 8'd0, 16'd0, 16'hffff, 64'd0}, ROW_PREDICT, '0);
		add_row({ACT_WR_REGS, 8'd0, 16'd1, 16'hffff, {$urandom, $urandom}}, ROW_PREDICT, '0);
		add_row({ACT_WR_REG, 8'd0, 16'd0, 16'd1, 64'd0}, ROW_PREDICT, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		k = 0;
		while (k < plan.size() || sent_requests < TOTAL_REQUESTS) begin
			if (k < plan.size())
				send_request(plan[k].r, plan[k].kind, plan[k].want);
			else
				send_request(random_request(), ROW_PREDICT, '0);
			if (k == 300 || k == 900) begin
				// drain everything before going on
				start = 1'b0;
				while (expected_replies.size() != 0)
					@(negedge clk);
				repeat (4) @(negedge clk);
			end else if ((k < 500 || k >= 800) && $urandom_range(0, 99) < 9) begin
				start = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			k++;
		end
		start = 1'b0;

		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d requests, %0d dropped by the address filter, %0d replies checked",
			sent_requests, dropped_requests, checked_replies);
		$display("answered per operation: %0d %0d %0d %0d %0d %0d %0d %0d",
			action_count[0], action_count[1], action_count[2], action_count[3],
			action_count[4], action_count[5], action_count[6], action_count[7]);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
